// ===== rtl/core/crmsd_pkg.sv =====
// Package with shared types and constants for the column running mean/stddev block.
package crmsd_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [1:0] STATUS_FEW_ROWS  = 2'd2;
    localparam logic [1:0] STATUS_BAD_COL   = 2'd3;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request and read the column store
        logic div_start;  // start the iterative divider
        logic mean_step;  // form the new mean from the quotient
        logic mul_step;   // one partial product of the squared deviation
        logic acc_step;   // accumulate and write back
        logic sqrt_start; // start the square root
        logic sqrt_step;  // one square-root iteration
        logic fin_report; // form the report result
        logic fin_sample; // form the sample result
    } crmsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init;       // clearing pass after reset still running
        logic bad_col;
        logic report;
        logic few_rows;
        logic div_done;
        logic sqrt_done;
        logic var_big;
    } crmsd_sts_t;

endpackage

// ===== rtl/core/crmsd_ctrl.sv =====
// Controller state machine sequencing sample updates and reports.
module crmsd_ctrl
    import crmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_free,
    input  crmsd_sts_t sts,
    output crmsd_cmd_t cmd,
    output logic       busy,
    output logic       result_load
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_READ   = 4'd1;
    localparam logic [3:0] ST_SDIV   = 4'd2;
    localparam logic [3:0] ST_MEAN   = 4'd3;
    localparam logic [3:0] ST_MUL0   = 4'd4;
    localparam logic [3:0] ST_MUL1   = 4'd5;
    localparam logic [3:0] ST_ACC    = 4'd6;
    localparam logic [3:0] ST_RDIV   = 4'd7;
    localparam logic [3:0] ST_SQRT   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_SQWAIT = 4'd10;
    localparam logic [3:0] ST_FETCH  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       rep_reg, rep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rep_reg   <= rep_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rep_next    = rep_reg;
        cmd         = '0;
        result_load = 1'b0;
        busy        = (state_reg != ST_IDLE) || sts.init;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // The column store read for the new column lands at the end of this cycle.
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (sts.bad_col)
                begin
                    rep_next   = 1'b0;
                    state_next = ST_OUT;
                end
                else if (sts.report)
                begin
                    rep_next = 1'b1;
                    if (sts.few_rows)
                        state_next = ST_OUT;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_RDIV;
                    end
                end
                else
                begin
                    rep_next      = 1'b0;
                    cmd.div_start = 1'b1;
                    state_next    = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                if (sts.div_done)
                    state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                cmd.mean_step = 1'b1;
                state_next    = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_step = 1'b1;
                state_next   = ST_OUT;
            end
            ST_RDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sts.var_big || sts.sqrt_done)
                    state_next = ST_SQWAIT;
                else
                    cmd.sqrt_step = 1'b1;
            end
            ST_SQWAIT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_load = 1'b1;
                    if (rep_reg)
                        cmd.fin_report = 1'b1;
                    else
                        cmd.fin_sample = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/crmsd_datapath.sv =====
// Datapath: column stores, row counter, iterative divider, multiplier and square root.
module crmsd_datapath
    import crmsd_pkg::*;
#(
    parameter int MAX_COLUMNS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  cfg_data,
    input  logic        cfg_fire,
    input  logic        in_mode,
    input  logic [6:0]  in_column,
    input  logic [31:0] in_sample,
    input  logic        in_end_of_row,
    input  crmsd_cmd_t  cmd,
    output crmsd_sts_t  sts,
    output logic [1:0]  res_status,
    output logic [31:0] res_mean,
    output logic [31:0] res_std_dev,
    output logic [31:0] res_rows_seen
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = $clog2(MAX_COLUMNS + 1);

    // Clearing pass after reset walks through the stores.
    logic [AW:0]  clr_cnt_reg;
    logic         clearing;
    assign clearing = (clr_cnt_reg < (AW + 1)'(MAX_COLUMNS));

    logic [31:0] mean_mem [MAX_COLUMNS];
    logic [63:0] ssq_mem  [MAX_COLUMNS];

    logic [7:0]  ncfg_reg;
    logic [31:0] rows_reg;
    logic        mode_reg, eor_reg;
    logic [6:0]  col_reg;
    logic signed [32:0] x_reg;
    logic [31:0] mrd_reg;
    logic [63:0] srd_reg;
    logic        bad_reg, mism_reg;

    // Columns in use, clamped.
    logic [NW-1:0] ncol;
    always_comb
    begin
        if (ncfg_reg == 8'd0)
            ncol = NW'(1);
        else if ({24'd0, ncfg_reg} > 32'(MAX_COLUMNS))
            ncol = NW'(MAX_COLUMNS);
        else
            ncol = NW'(ncfg_reg);
    end

    logic [AW-1:0] addr;
    assign addr = AW'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            ncfg_reg    <= 8'd1;
        end
        else
        begin
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_fire)
                ncfg_reg <= cfg_data;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            col_reg  <= in_column;
            x_reg    <= {in_sample[31], in_sample};
            eor_reg  <= in_end_of_row;
            bad_reg  <= (32'(in_column) >= 32'(ncol));
        end
    end

    // Divider: magnitude (64 bit) / divisor (33 bit), one bit per cycle.
    logic [63:0] dnum_reg, dquo_reg;
    logic [64:0] drem_reg;
    logic [32:0] dden_reg;
    logic [6:0]  dcnt_reg;
    logic        dbusy_reg;
    logic        dneg_reg;
    logic [32:0] dmag_reg;

    logic signed [33:0] delta_c;
    assign delta_c = 34'(x_reg) - 34'($signed(mrd_reg));

    logic [64:0] dtrial;
    assign dtrial = {drem_reg[63:0], dnum_reg[63]} - {32'd0, dden_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= mode_reg ? 7'd64 : 7'd33;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == 7'd1)
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            drem_reg <= '0;
            dquo_reg <= '0;
            if (mode_reg)
            begin
                dnum_reg <= srd_reg;
                dden_reg <= {1'b0, rows_reg - 32'd1};
            end
            else
            begin
                dneg_reg  <= delta_c[33];
                dmag_reg  <= delta_c[33] ? 33'(-delta_c) : delta_c[32:0];
                dnum_reg  <= {(delta_c[33] ? 33'(-delta_c) : delta_c[32:0]), 31'd0};
                dden_reg  <= {1'b0, rows_reg} + 33'd1;
            end
        end
        else if (dbusy_reg)
        begin
            dnum_reg <= {dnum_reg[62:0], 1'b0};
            if (!dtrial[64])
            begin
                drem_reg <= dtrial;
                dquo_reg <= {dquo_reg[62:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[63:0], dnum_reg[63]};
                dquo_reg <= {dquo_reg[62:0], 1'b0};
            end
        end
    end

    // New mean and the squared-deviation product in two partial steps, 33x17 and 33x16.
    logic signed [33:0] newm_reg;
    logic [32:0] d2_reg;
    logic [65:0] prod_reg;
    logic        mphase_reg;

    logic signed [33:0] newm_c;
    assign newm_c = dneg_reg ? (34'($signed(mrd_reg)) - 34'(dquo_reg[32:0]))
                             : (34'($signed(mrd_reg)) + 34'(dquo_reg[32:0]));
    logic signed [34:0] d2s_c;
    assign d2s_c = 35'(x_reg) - 35'(newm_c);

    logic [32:0] d2_half;
    assign d2_half = mphase_reg ? {17'd0, d2_reg[32:17]} : {16'd0, d2_reg[16:0]};
    logic [49:0] pp;
    assign pp = 50'(dmag_reg) * 50'(d2_half);

    logic [63:0] addv;
    assign addv = 64'(prod_reg >> 16);
    logic [64:0] ssum;
    assign ssum = {1'b0, srd_reg} + {1'b0, addv};

    always_ff @(posedge clk)
    begin
        if (cmd.mean_step)
        begin
            newm_reg   <= newm_c;
            d2_reg     <= d2s_c[34] ? 33'(-d2s_c) : d2s_c[32:0];
            prod_reg   <= '0;
            mphase_reg <= 1'b0;
        end
        else if (cmd.mul_step)
        begin
            mphase_reg <= 1'b1;
            if (mphase_reg)
                prod_reg <= prod_reg + {pp[48:0], 17'd0};
            else
                prod_reg <= 66'(pp);
        end
    end

    // Store access.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mean_mem[clr_cnt_reg[AW-1:0]] <= '0;
            ssq_mem[clr_cnt_reg[AW-1:0]]  <= '0;
        end
        else if (cmd.acc_step)
        begin
            mean_mem[addr] <= newm_reg[31:0];
            ssq_mem[addr]  <= ssum[64] ? '1 : ssum[63:0];
        end
        mrd_reg <= mean_mem[addr];
        srd_reg <= ssq_mem[addr];
    end

    // Square root of var << 16 (fits 64 bits when var < 2^48).
    logic [63:0] sv_reg, sres_reg, sbit_reg;
    logic        sbig_reg;
    logic [63:0] ssum_c;
    assign ssum_c = sres_reg + sbit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sbig_reg <= (dquo_reg[63:48] != 16'd0);
            sv_reg   <= {dquo_reg[47:0], 16'd0};
            sres_reg <= '0;
            sbit_reg <= 64'd1 << 62;
        end
        else if (cmd.sqrt_step)
        begin
            if (sv_reg >= ssum_c)
            begin
                sv_reg   <= sv_reg - ssum_c;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_reg <= sres_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // Row counter and result formation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_reg <= '0;
        else if (cmd.fin_sample && !bad_reg && eor_reg && rows_reg != 32'hFFFF_FFFF)
            rows_reg <= rows_reg + 32'd1;
    end

    assign mism_reg = eor_reg != (32'(col_reg) == 32'(ncol) - 32'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.fin_sample)
        begin
            res_mean    <= '0;
            res_std_dev <= '0;
            if (bad_reg)
            begin
                res_status    <= STATUS_BAD_COL;
                res_rows_seen <= rows_reg;
            end
            else
            begin
                res_status    <= mism_reg ? STATUS_MISMATCH : STATUS_OK;
                res_rows_seen <= (eor_reg && rows_reg != 32'hFFFF_FFFF) ?
                                 rows_reg + 32'd1 : rows_reg;
            end
        end
        else if (cmd.fin_report)
        begin
            res_rows_seen <= rows_reg;
            if (bad_reg)
            begin
                res_status  <= STATUS_BAD_COL;
                res_mean    <= '0;
                res_std_dev <= '0;
            end
            else if (rows_reg < 32'd2)
            begin
                res_status  <= STATUS_FEW_ROWS;
                res_mean    <= mrd_reg;
                res_std_dev <= '0;
            end
            else
            begin
                res_status  <= STATUS_OK;
                res_mean    <= mrd_reg;
                res_std_dev <= sbig_reg ? 32'hFFFF_FFFF :
                               (sres_reg[63:32] != 32'd0 ? 32'hFFFF_FFFF : sres_reg[31:0]);
            end
        end
    end

    assign sts.init      = clearing;
    assign sts.bad_col   = bad_reg;
    assign sts.report    = mode_reg;
    assign sts.few_rows  = rows_reg < 32'd2;
    assign sts.div_done  = !dbusy_reg && !cmd.div_start;
    assign sts.sqrt_done = (sbit_reg == 64'd0);
    assign sts.var_big   = sbig_reg;

endmodule

// ===== rtl/core/column_running_mean_stddev.sv =====
// Top level of the per-column running mean and standard deviation block.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | tdata {sample, column}, tuser mode, tlast end_of_row
//   m_axis   | out       | tdata {rows_seen, std_dev, mean, status}
//   cfg      | in        | cfg_data = num_columns
//
// A sample request runs capture, the column store read, the 33-step bit-serial
// divider that forms delta / n, the new mean, two partial products, the
// write-back and the load before the next request is taken. A report runs a
// 64-step divide of the sum of squares by rows - 1 and 32 square-root steps;
// the square root is skipped when the variance is too large, and both when there
// are fewer than two rows or the column is out of range. After reset a clearing
// pass zeroes the column stores; no request is taken during it. One request is
// in flight at a time; a stalled master side holds the result and the block.
module column_running_mean_stddev
    import crmsd_pkg::*;
#(
    parameter int MAX_COLUMNS = 128
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // [6:0] column, [38:7] sample, pad
    input  logic         s_axis_tuser,  // [0] mode
    input  logic         s_axis_tlast,  // end_of_row
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata   // [1:0] status, [33:2] mean, [65:34] std_dev,
                                        // [97:66] rows_seen, pad
);

    crmsd_cmd_t  cmd;
    crmsd_sts_t  sts;
    logic        busy, result_load, in_fire, out_valid_reg;
    logic [1:0]  r_status;
    logic [31:0] r_mean, r_sd, r_rows;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    crmsd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .out_free    (!out_valid_reg || m_axis_tready),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy),
        .result_load (result_load)
    );

    crmsd_datapath #(.MAX_COLUMNS(MAX_COLUMNS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_data      (cfg_data),
        .cfg_fire      (cfg_valid),
        .in_mode       (s_axis_tuser),
        .in_column     (s_axis_tdata[6:0]),
        .in_sample     (s_axis_tdata[38:7]),
        .in_end_of_row (s_axis_tlast),
        .cmd           (cmd),
        .sts           (sts),
        .res_status    (r_status),
        .res_mean      (r_mean),
        .res_std_dev   (r_sd),
        .res_rows_seen (r_rows)
    );

    // The result valid flag rises with a load and falls when the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, r_rows, r_sd, r_mean, r_status};

endmodule
